/* sv/id_allocator_with_free_queue_top_macros.svh */
// assertion macros for the identifier allocator
`ifndef ID_ALLOCATOR_WITH_FREE_QUEUE_TOP_MACROS_SVH
`define ID_ALLOCATOR_WITH_FREE_QUEUE_TOP_MACROS_SVH

// checked only outside reset
`define IDA_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);

// checked on every edge, reset included
`define IDA_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

/* sv/ida_pkg.sv */
// shared types and constants of the identifier allocator
`timescale 1ns / 1ps
`default_nettype none

package ida_pkg;

    localparam int unsigned NUM_IDS_DEF = 256;
    localparam int unsigned ID_W        = 8;
    localparam int unsigned STATUS_W    = 2;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK           = 2'd0,
        STATUS_EXHAUSTED    = 2'd1,
        STATUS_NEVER_ISSUED = 2'd2,
        STATUS_QUEUE_FULL   = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_READ = 2'b10
    } state_t;

endpackage

`default_nettype wire

/* sv/id_allocator_with_free_queue_top.sv */
// identifier allocator: fresh counter plus a free queue held in one synchronous memory
//
//  channel  | direction | tdata             | tuser
//  ---------+-----------+-------------------+----------------------------
//  s_       | in        | [7:0] release_id  | [0] op (0 acquire, 1 release)
//  m_       | out       | [7:0] granted_id  | [1:0] status
//
// one result beat per input beat. an acquire served from the free queue is read
// from the queue memory into a read register, then loaded into the output
// register; every other beat loads the output register directly. a new beat is
// taken when no queue read is pending and the output register is empty or being
// drained. reset clears pointers, count and fresh counter at once; the queue
// memory is not cleared, entries are read only after they were written.
`timescale 1ns / 1ps
`default_nettype none

module id_allocator_with_free_queue_top #(
    parameter int unsigned NUM_IDS = ida_pkg::NUM_IDS_DEF
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       s_tvalid,
    output logic                            s_tready,
    input  wire logic [ida_pkg::ID_W-1:0]   s_tdata,   // [7:0] release_id
    input  wire logic [0:0]                 s_tuser,   // [0] op
    output logic                            m_tvalid,
    input  wire logic                       m_tready,
    output logic [ida_pkg::ID_W-1:0]        m_tdata,   // [7:0] granted_id
    output logic [ida_pkg::STATUS_W-1:0]    m_tuser    // [1:0] status
);

    import ida_pkg::*;

    localparam int unsigned PTR_W = (NUM_IDS > 1) ? $clog2(NUM_IDS) : 1;
    localparam int unsigned CNT_W = $clog2(NUM_IDS + 1);
    localparam int unsigned CMP_W = (CNT_W > ID_W) ? CNT_W : ID_W;

    logic [ID_W-1:0]  queue_mem [NUM_IDS];
    logic [ID_W-1:0]  rd_data_reg;

    state_t           state_reg, state_next;
    logic [PTR_W-1:0] head_reg, head_next;
    logic [PTR_W-1:0] tail_reg, tail_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] fresh_reg, fresh_next;

    logic             m_tvalid_reg, m_tvalid_next;
    logic [ID_W-1:0]  granted_reg, granted_next;
    status_t          status_reg, status_next;

    logic             accept;
    logic             is_release;
    logic             rd_en;
    logic             wr_en;
    logic             out_load;
    logic             queue_empty;
    logic             queue_full;
    logic             fresh_left;
    logic             never_issued;

    // no beat is taken while reset is held
    assign s_tready    = aresetn && (state_reg == ST_IDLE) && (!m_tvalid_reg || m_tready);
    assign accept      = s_tvalid && s_tready;
    assign is_release  = s_tuser[0];
    assign queue_empty = (count_reg == '0);
    assign queue_full  = (count_reg == CNT_W'(NUM_IDS));
    assign fresh_left  = (fresh_reg < CNT_W'(NUM_IDS));
    assign never_issued = (CMP_W'(s_tdata) >= CMP_W'(fresh_reg));

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = granted_reg;
    assign m_tuser  = status_reg;

    always_comb begin
        state_next   = state_reg;
        head_next    = head_reg;
        tail_next    = tail_reg;
        count_next   = count_reg;
        fresh_next   = fresh_reg;
        granted_next = granted_reg;
        status_next  = status_reg;
        rd_en        = 1'b0;
        wr_en        = 1'b0;
        out_load     = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (!is_release) begin
                        if (!queue_empty) begin
                            // oldest released id comes back from memory next cycle
                            rd_en      = 1'b1;
                            head_next  = (head_reg == PTR_W'(NUM_IDS - 1)) ?
                                         '0 : head_reg + 1'b1;
                            count_next = count_reg - 1'b1;
                            state_next = ST_READ;
                        end else if (fresh_left) begin
                            out_load     = 1'b1;
                            granted_next = ID_W'(fresh_reg);
                            status_next  = STATUS_OK;
                            fresh_next   = fresh_reg + 1'b1;
                        end else begin
                            out_load     = 1'b1;
                            granted_next = '0;
                            status_next  = STATUS_EXHAUSTED;
                        end
                    end else begin
                        out_load     = 1'b1;
                        granted_next = '0;
                        if (never_issued) begin
                            status_next = STATUS_NEVER_ISSUED;
                        end else if (queue_full) begin
                            status_next = STATUS_QUEUE_FULL;
                        end else begin
                            status_next = STATUS_OK;
                            wr_en       = 1'b1;
                            tail_next   = (tail_reg == PTR_W'(NUM_IDS - 1)) ?
                                          '0 : tail_reg + 1'b1;
                            count_next  = count_reg + 1'b1;
                        end
                    end
                end
            end
            ST_READ: begin
                out_load     = 1'b1;
                granted_next = rd_data_reg;
                status_next  = STATUS_OK;
                state_next   = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        m_tvalid_next = m_tvalid_reg && !m_tready;
        if (out_load) begin
            m_tvalid_next = 1'b1;
        end
    end

    // free queue memory, one write and one registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            queue_mem[tail_reg] <= s_tdata;
        end
        if (rd_en) begin
            rd_data_reg <= queue_mem[head_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            head_reg     <= '0;
            tail_reg     <= '0;
            count_reg    <= '0;
            fresh_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            head_reg     <= head_next;
            tail_reg     <= tail_next;
            count_reg    <= count_next;
            fresh_reg    <= fresh_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        granted_reg <= granted_next;
        status_reg  <= status_next;
    end

`include "id_allocator_with_free_queue_top_macros.svh"

    `IDA_ASSERT(a_count_bound, (count_reg <= CNT_W'(NUM_IDS)), "free queue count out of range")
    `IDA_ASSERT(a_fresh_bound, (fresh_reg <= CNT_W'(NUM_IDS)), "fresh counter out of range")
    `IDA_ASSERT(a_read_slot_free,
        (state_reg == ST_READ) |-> !m_tvalid_reg,
        "output busy during queue read")
    `IDA_ASSERT(a_state_quiet,
        (aresetn && !accept) |=> ($stable(count_reg) && $stable(fresh_reg)),
        "state moved without a beat")
    `IDA_ASSERT_ALWAYS(a_reset_clear,
        (!aresetn) |=> (count_reg == '0 && !m_tvalid_reg),
        "reset left state behind")

endmodule

`default_nettype wire
